@@ sv/sha1_pkg.sv @@
`default_nettype none

package sha1_pkg;

	localparam int unsigned NUM_ROUNDS = 80;
	localparam int unsigned NUM_HASH   = 5;

	localparam logic [31:0] MARKER_WORD = 32'h8000_0000;

	localparam logic [31:0] K_00_19 = 32'h5A82_7999;
	localparam logic [31:0] K_20_39 = 32'h6ED9_EBA1;
	localparam logic [31:0] K_40_59 = 32'h8F1B_BCDC;
	localparam logic [31:0] K_60_79 = 32'hCA62_C1D6;

	localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);
	localparam logic [2:0] LAST_INDEX = 3'd4;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  byte_count;
		logic        final_word;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  digest_index;
		logic        digest_last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef logic [31:0] hash_t [NUM_HASH];

	// schedule window control
	typedef struct packed {
		logic        push;
		logic [31:0] push_data;
		logic        step;
		logic        early;
	} sched_ctrl_t;

	// round unit control
	typedef struct packed {
		logic       load;
		logic       step;
		logic [6:0] rnd;
	} round_ctrl_t;

	function automatic logic [31:0] h_init(input logic [2:0] idx);
		logic [31:0] v;
		unique case (idx)
			3'd0:    v = 32'h6745_2301;
			3'd1:    v = 32'hEFCD_AB89;
			3'd2:    v = 32'h98BA_DCFE;
			3'd3:    v = 32'h1032_5476;
			default: v = 32'hC3D2_E1F0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

endpackage

`default_nettype wire

@@ sv/sha1_sched.sv @@
`default_nettype none

module sha1_sched
	import sha1_pkg::*;
(
	input  wire logic        clk,
	input  wire sched_ctrl_t ctrl,
	output logic [31:0]      wt
);

	// w_q[0] is the oldest word of the window
	logic [31:0] w_q [16];
	logic [31:0] shift_in;

	always_comb begin
		if (ctrl.early) begin
			wt = w_q[0];
		end else begin
			wt = rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);
		end
		shift_in = ctrl.push ? ctrl.push_data : wt;
	end

	always_ff @(posedge clk) begin
		if (ctrl.push || ctrl.step) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= shift_in;
		end
	end

endmodule

`default_nettype wire

@@ sv/sha1_round.sv @@
`default_nettype none

module sha1_round
	import sha1_pkg::*;
(
	input  wire logic        clk,
	input  wire round_ctrl_t ctrl,
	input  wire hash_t       chain,
	input  wire logic [31:0] wt,
	output hash_t            vars
);

	hash_t       v_q;
	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] t;

	always_comb begin
		if (ctrl.rnd < 7'd20) begin
			f = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
			k = K_00_19;
		end else if (ctrl.rnd < 7'd40) begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = K_20_39;
		end else if (ctrl.rnd < 7'd60) begin
			f = (v_q[1] & v_q[2]) | (v_q[2] & v_q[3]) | (v_q[1] & v_q[3]);
			k = K_40_59;
		end else begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = K_60_79;
		end
		t = {v_q[0][26:0], v_q[0][31:27]} + f + v_q[4] + k + wt;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			v_q <= chain;
		end else if (ctrl.step) begin
			v_q[0] <= t;
			v_q[1] <= v_q[0];
			v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3];
		end
	end

	assign vars = v_q;

endmodule

`default_nettype wire

@@ sv/sha1_hash_engine.sv @@
// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_ready      in_data  (in_item_t)
// out      output     out_valid / out_ready    out_data (out_item_t)
//
// A word that does not fill the block is only pushed; the word that fills it adds all
// NUM_ROUNDS rounds on the single round unit plus one fold into the chain.
// A final word brings padding at one word a cycle, held while a block is compressed,
// one or two compressions, then five digest items; ready is low from the final word
// until the fifth is taken. Reset restores the initial chain and clears length, position
// and sequencer. A stalled output holds its item; no input is taken meanwhile.
`default_nettype none

module sha1_hash_engine
	import sha1_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	state_t      state_q, state_d;
	logic [3:0]  pos_q;
	logic [63:0] bits_q;
	logic        marker_q;
	logic        lenhi_q;
	logic        padding_q;
	logic        last_q;
	logic [6:0]  rnd_q;
	logic [2:0]  oidx_q;
	hash_t       chain_q;

	hash_t       vars;
	logic [31:0] wt;
	sched_ctrl_t sched_ctrl;
	round_ctrl_t round_ctrl;

	logic        push;
	logic [31:0] push_data;
	logic [2:0]  cnt;
	logic [31:0] mask;
	logic [31:0] marker;
	logic [31:0] final_data;

	// tail of the final word: keep valid bytes, marker in the first spare byte
	always_comb begin
		cnt = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
		unique case (cnt)
			3'd0: begin
				mask   = 32'h0000_0000;
				marker = 32'h8000_0000;
			end
			3'd1: begin
				mask   = 32'hFF00_0000;
				marker = 32'h0080_0000;
			end
			3'd2: begin
				mask   = 32'hFFFF_0000;
				marker = 32'h0000_8000;
			end
			3'd3: begin
				mask   = 32'hFFFF_FF00;
				marker = 32'h0000_0080;
			end
			default: begin
				mask   = 32'hFFFF_FFFF;
				marker = 32'h0000_0000;
			end
		endcase
		final_data = (in_data.message_word & mask) | marker;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (pos_q == 4'd15) begin
						state_d = ST_ROUND;
					end else if (in_data.final_word) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (pos_q == 4'd15) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				priority if (last_q) begin
					state_d = ST_OUT;
				end else if (padding_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_ready && oidx_q == LAST_INDEX) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and unit control
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		push      = 1'b0;
		push_data = in_data.message_word;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				push     = in_valid;
				if (in_data.final_word) begin
					push_data = final_data;
				end
			end
			ST_PAD: begin
				push = 1'b1;
				priority if (marker_q) begin
					push_data = MARKER_WORD;
				end else if (lenhi_q) begin
					push_data = bits_q[31:0];
				end else if (pos_q == 4'd14) begin
					push_data = bits_q[63:32];
				end else begin
					push_data = '0;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
			end
		endcase

		sched_ctrl.push      = push;
		sched_ctrl.push_data = push_data;
		sched_ctrl.step      = (state_q == ST_ROUND);
		sched_ctrl.early     = (rnd_q < 7'd16);

		round_ctrl.load = (state_d == ST_ROUND) && (state_q != ST_ROUND);
		round_ctrl.step = (state_q == ST_ROUND);
		round_ctrl.rnd  = rnd_q;

		out_data.digest_word  = chain_q[oidx_q];
		out_data.digest_index = oidx_q;
		out_data.digest_last  = (oidx_q == LAST_INDEX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			bits_q    <= '0;
			marker_q  <= 1'b0;
			lenhi_q   <= 1'b0;
			padding_q <= 1'b0;
			last_q    <= 1'b0;
			rnd_q     <= '0;
			oidx_q    <= '0;
			for (int i = 0; i < NUM_HASH; i++) begin
				chain_q[i] <= h_init(3'(i));
			end
		end else begin
			state_q <= state_d;
			if (push) begin
				pos_q <= pos_q + 4'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_data.final_word) begin
							bits_q    <= bits_q + {58'd0, cnt, 3'b000};
							padding_q <= 1'b1;
							marker_q  <= (cnt == 3'd4);
						end else begin
							bits_q <= bits_q + 64'd32;
						end
					end
				end
				ST_PAD: begin
					priority if (marker_q) begin
						marker_q <= 1'b0;
					end else if (lenhi_q) begin
						lenhi_q <= 1'b0;
						last_q  <= 1'b1;
					end else if (pos_q == 4'd14) begin
						lenhi_q <= 1'b1;
					end else begin
					end
				end
				ST_ROUND: begin
					rnd_q <= (rnd_q == LAST_ROUND) ? 7'd0 : rnd_q + 7'd1;
				end
				ST_FOLD: begin
					for (int i = 0; i < NUM_HASH; i++) begin
						chain_q[i] <= chain_q[i] + vars[i];
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						if (oidx_q == LAST_INDEX) begin
							oidx_q    <= '0;
							bits_q    <= '0;
							padding_q <= 1'b0;
							last_q    <= 1'b0;
							for (int i = 0; i < NUM_HASH; i++) begin
								chain_q[i] <= h_init(3'(i));
							end
						end else begin
							oidx_q <= oidx_q + 3'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	sha1_sched u_sched (
		.clk  (clk),
		.ctrl (sched_ctrl),
		.wt   (wt)
	);

	sha1_round u_round (
		.clk   (clk),
		.ctrl  (round_ctrl),
		.chain (chain_q),
		.wt    (wt),
		.vars  (vars)
	);

endmodule

`default_nettype wire
